// ===== rtl/mbfd_pkg.sv =====
// ============================================================================
// mbfd_pkg
// Shared types, constants and helper functions of the message-bus deframer.
// ============================================================================
package mbfd_pkg;

    localparam int POS_W  = 34;
    localparam int LEN_W  = 32;
    localparam int IDX_W  = 3;
    localparam int KIND_W = 3;

    // Number of header fields that follow the fixed header.
    localparam logic [IDX_W-1:0] PARAM_COUNT = 3'd4;

    localparam logic [POS_W-1:0] BODY_RCV_MAX = {POS_W{1'b1}};

    typedef enum logic [2:0] {
        PH_HDR   = 3'd0,
        PH_PHDR  = 3'd1,
        PH_PDATA = 3'd2,
        PH_SIG   = 3'd3,
        PH_BODY  = 3'd4
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        KIND_SERIAL    = 3'd0,
        KIND_PATH      = 3'd1,
        KIND_DEST      = 3'd2,
        KIND_INTERFACE = 3'd3,
        KIND_METHOD    = 3'd4,
        KIND_SIGNATURE = 3'd5,
        KIND_UNKNOWN   = 3'd6,
        KIND_BODY      = 3'd7
    } t_kind;

    localparam logic [7:0] CODE_PATH      = 8'd1;
    localparam logic [7:0] CODE_INTERFACE = 8'd2;
    localparam logic [7:0] CODE_METHOD    = 8'd3;
    localparam logic [7:0] CODE_DEST      = 8'd6;
    localparam logic [7:0] CODE_SIGNATURE = 8'd9;

    function automatic t_kind kind_of_code(input logic [7:0] code);
        t_kind k;
        unique case (code)
            CODE_PATH:      k = KIND_PATH;
            CODE_DEST:      k = KIND_DEST;
            CODE_INTERFACE: k = KIND_INTERFACE;
            CODE_METHOD:    k = KIND_METHOD;
            CODE_SIGNATURE: k = KIND_SIGNATURE;
            default:        k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    // Round up to the next multiple of eight.
    function automatic logic [POS_W-1:0] round8(input logic [POS_W-1:0] v);
        logic [POS_W-1:0] s;
        s = v + POS_W'(7);
        return {s[POS_W-1:3], 3'b000};
    endfunction

endpackage

// ===== rtl/mbfd_in_if.sv =====
// ============================================================================
// mbfd_in_if
// Byte stream channel into the deframer: valid, ready and one raw byte.
// ============================================================================
interface mbfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== rtl/mbfd_out_if.sv =====
// ============================================================================
// mbfd_out_if
// Tagged content byte channel out of the deframer.
// ============================================================================
interface mbfd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] field_kind;
    logic [7:0] content_byte;
    logic       field_last;
    logic       message_end;

    modport source (output valid, output field_kind, output content_byte,
                    output field_last, output message_end, input ready);
    modport sink   (input valid, input field_kind, input content_byte,
                    input field_last, input message_end, output ready);
endinterface

// ===== rtl/message_bus_frame_deframer.sv =====
// ============================================================================
// message_bus_frame_deframer
// Walks a message-bus frame one byte at a time and passes on the content
// bytes of the serial, header fields and body strings, tagged by field.
// ============================================================================
//
//  Channel  Dir  Payload                                         Transfer
//  i_in     in   data_byte[7:0]                                  valid & ready
//  o_out    out  field_kind[2:0] content_byte[7:0]               valid & ready
//                field_last message_end
//
//  The phase and counters update in the cycle of the input transfer and the
//  result lands in the output register, so one byte per cycle is sustained
//  while the output is not stalled; the 34-bit position add and compare
//  sets the cycle time. Input is taken while the output register is empty
//  or being drained. Synchronous reset returns the block to the start of a
//  header; there is no clearing pass.
//
module message_bus_frame_deframer
    import mbfd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    mbfd_in_if.sink           i_in,
    mbfd_out_if.source        o_out
);

    t_phase             r_phase, n_phase;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [LEN_W-1:0]   r_body_len, n_body_len;
    logic [POS_W-1:0]   r_span, n_span;
    logic [IDX_W-1:0]   r_idx, n_idx;
    t_kind              r_kind, n_kind;
    logic [POS_W-1:0]   r_body_rcv, n_body_rcv;
    logic               r_in_string, n_in_string;

    logic               r_out_valid;
    t_kind              r_out_kind;
    logic [7:0]         r_out_byte;
    logic               r_out_last;
    logic               r_out_end;

    logic               accept;
    logic               emit;
    t_kind              res_kind;
    logic               res_last;
    logic               res_end;
    logic [7:0]         b;
    logic [4:0]         byte_sh;
    logic [POS_W-1:0]   pos_inc;
    logic [POS_W-1:0]   span_w;
    logic [IDX_W-1:0]   idx_inc;

    assign b       = i_in.data_byte;
    assign accept  = i_in.valid && i_in.ready;
    assign pos_inc = r_pos + POS_W'(1);
    assign idx_inc = r_idx + IDX_W'(1);
    // Little-endian length bytes sit at positions 4 to 7.
    assign byte_sh = {r_pos[1:0], 3'b000};

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_body_len  = r_body_len;
        n_span      = r_span;
        n_idx       = r_idx;
        n_kind      = r_kind;
        n_body_rcv  = r_body_rcv;
        n_in_string = r_in_string;
        emit        = 1'b0;
        res_kind    = KIND_SERIAL;
        res_last    = 1'b0;
        res_end     = 1'b0;
        span_w      = r_span;

        unique case (r_phase)
            PH_HDR: begin
                if (r_pos >= POS_W'(4) && r_pos <= POS_W'(7)) begin
                    if (r_pos == POS_W'(4)) begin
                        n_body_len = LEN_W'(b);
                    end else begin
                        n_body_len = r_body_len | (LEN_W'(b) << byte_sh);
                    end
                end
                if (r_pos >= POS_W'(8) && r_pos <= POS_W'(11)) begin
                    emit     = 1'b1;
                    res_kind = KIND_SERIAL;
                    res_last = (r_pos == POS_W'(11));
                end
                n_pos = pos_inc;
                if (pos_inc >= POS_W'(16)) begin
                    n_phase = PH_PHDR;
                    n_pos   = '0;
                    n_idx   = '0;
                end
            end
            PH_PHDR: begin
                if (r_pos == '0) begin
                    n_kind = kind_of_code(b);
                end
                if (r_pos >= POS_W'(4) && r_pos <= POS_W'(7)) begin
                    if (r_pos == POS_W'(4)) begin
                        span_w = POS_W'(b);
                    end else begin
                        span_w = r_span | (POS_W'(b) << byte_sh);
                    end
                end
                n_span = span_w;
                n_pos  = pos_inc;
                if (pos_inc >= POS_W'(8)) begin
                    // Content is the length plus its nul, padded to eight.
                    n_span  = round8(span_w + POS_W'(1));
                    n_phase = PH_PDATA;
                    n_pos   = '0;
                end
            end
            PH_PDATA: begin
                emit     = 1'b1;
                res_kind = r_kind;
                if (pos_inc >= r_span) begin
                    res_last = 1'b1;
                    n_idx    = idx_inc;
                    n_pos    = '0;
                    if (idx_inc >= PARAM_COUNT) begin
                        if (r_body_len != '0) begin
                            n_phase = PH_SIG;
                        end else begin
                            res_end = 1'b1;
                            n_phase = PH_HDR;
                        end
                    end else begin
                        n_phase = PH_PHDR;
                    end
                end else begin
                    n_pos = pos_inc;
                end
            end
            PH_SIG: begin
                if (r_pos == POS_W'(4)) begin
                    n_span = round8(POS_W'(b) + POS_W'(6));
                end
                if (r_pos >= POS_W'(4) && pos_inc >= n_span) begin
                    n_phase     = PH_BODY;
                    n_pos       = '0;
                    n_body_rcv  = '0;
                    n_in_string = 1'b0;
                end else begin
                    n_pos = pos_inc;
                end
            end
            PH_BODY: begin
                if (r_body_rcv < BODY_RCV_MAX) begin
                    n_body_rcv = r_body_rcv + POS_W'(1);
                end
                if (!r_in_string) begin
                    // Skip the four-byte string prefix.
                    n_pos = pos_inc;
                    if (pos_inc >= POS_W'(4)) begin
                        n_in_string = 1'b1;
                        n_pos       = '0;
                    end
                end else begin
                    emit     = 1'b1;
                    res_kind = KIND_BODY;
                    if (b == 8'd0) begin
                        n_in_string = 1'b0;
                        n_pos       = '0;
                        if (n_body_rcv >= POS_W'(r_body_len)) begin
                            res_last = 1'b1;
                            res_end  = 1'b1;
                            n_phase  = PH_HDR;
                        end
                    end
                end
            end
            default: begin
                n_phase = PH_HDR;
                n_pos   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR;
            r_pos       <= '0;
            r_body_len  <= '0;
            r_span      <= '0;
            r_idx       <= '0;
            r_kind      <= KIND_SERIAL;
            r_body_rcv  <= '0;
            r_in_string <= 1'b0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_body_len  <= n_body_len;
            r_span      <= n_span;
            r_idx       <= n_idx;
            r_kind      <= n_kind;
            r_body_rcv  <= n_body_rcv;
            r_in_string <= n_in_string;
        end
    end

    // Output register: reloaded by each input transfer, full only for a content byte; emptied by a transfer out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= emit;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_out_kind <= res_kind;
            r_out_byte <= b;
            r_out_last <= res_last;
            r_out_end  <= res_end;
        end
    end

    assign i_in.ready         = !r_out_valid || o_out.ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.field_kind   = r_out_kind;
    assign o_out.content_byte = r_out_byte;
    assign o_out.field_last   = r_out_last;
    assign o_out.message_end  = r_out_end;

    // The end of a message always closes the field it belongs to.
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.message_end |-> o_out.field_last)
        else $error("message end without field last");

    // After the final byte of a message the walker waits for a new header.
    a_end_to_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && emit && res_end |=> r_phase == PH_HDR && r_pos == '0)
        else $error("message end did not return to header");

    // Serial bytes never end a message.
    a_serial_no_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.field_kind == KIND_SERIAL |-> !o_out.message_end)
        else $error("serial byte flagged as message end");

    // Header field walk stays within the configured field count.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PHDR || r_phase == PH_PDATA |-> r_idx < PARAM_COUNT)
        else $error("field index out of range");

endmodule
